// File: rtl/dvmm_pkg.sv
package dvmm_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_FRAMES  = 3'd0,
    CFG_WINDOW_FRAMES = 3'd1,
    CFG_FRAME_LEN     = 3'd2,
    CFG_REAL_ONLY     = 3'd3
  } cfg_reg_t;

  // Register widths and reset values
  localparam int DELAY_FRAMES_W  = 5;
  localparam int WINDOW_FRAMES_W = 6;
  localparam int FRAME_LEN_W     = 9;

  localparam logic [DELAY_FRAMES_W-1:0]  DELAY_FRAMES_RST  = 5'd0;
  localparam logic [WINDOW_FRAMES_W-1:0] WINDOW_FRAMES_RST = 6'd8;
  localparam logic [FRAME_LEN_W-1:0]     FRAME_LEN_RST     = 9'd256;

  // Default sizing
  localparam int DEF_MAX_BINS    = 256;
  localparam int DEF_MAX_WINDOW  = 32;
  localparam int DEF_MAX_DELAY   = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  // Address width for a memory of the given depth, at least one bit
  function automatic int addr_w(input int depth);
    int w;
    w = (depth > 1) ? $clog2(depth) : 1;
    return w;
  endfunction

endpackage

// File: rtl/delayed_vector_moving_mean.sv
// Frame-delayed sliding-window mean over complex bins.
//
// Input channel (in_valid / in_stall) carries one bin per transfer, bins of a
// frame in order. Output channel (out_valid / out_stall) returns one result
// per bin: the bin's window mean (sum over the frames in the window divided
// by their count, truncated toward zero), the frame count, an empty flag, the
// bin index and a frame-end mark. A frame first runs through a delay line of
// delay_frames frames before it joins the window.
// One bin is processed at a time; a new bin is taken only once the last one
// has been loaded into the output register. The bit-serial divider works on
// real and imaginary parts together, one quotient bit per cycle, over a
// numerator of SUM_W = SAMPLE_BITS + log2(MAX_WINDOW) bits. An empty window
// skips the divider. The result sits in an output register; a new bin is
// taken while it waits, and the block holds in its last step while out_valid
// and out_stall are both high. Reset (rst, synchronous) loads default
// registers and clears all counters at once; sums read as zero while the
// window is empty. Writing delay_frames, window_frames or frame_len clears
// the counters the same way; real_only changes nothing else.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
module delayed_vector_moving_mean #(
  parameter int MAX_BINS    = dvmm_pkg::DEF_MAX_BINS,
  parameter int MAX_WINDOW  = dvmm_pkg::DEF_MAX_WINDOW,
  parameter int MAX_DELAY   = dvmm_pkg::DEF_MAX_DELAY,
  parameter int SAMPLE_BITS = dvmm_pkg::DEF_SAMPLE_BITS,
  localparam int WCNT_W     = $clog2(MAX_WINDOW + 1),
  localparam int BIN_W      = dvmm_pkg::addr_w(MAX_BINS)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [dvmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dvmm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         sample_re,
  input  logic signed [SAMPLE_BITS-1:0]         sample_im,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         mean_re,
  output logic signed [SAMPLE_BITS-1:0]         mean_im,
  output logic [WCNT_W-1:0]                     frames_in_window,
  output logic                                  window_empty,
  output logic [BIN_W-1:0]                      bin_number,
  output logic                                  frame_end
);

  localparam int DCNT_W = $clog2(MAX_DELAY + 1);
  localparam int LEN_W  = $clog2(MAX_BINS + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int SMP2_W = 2 * SAMPLE_BITS;
  localparam int DDEPTH = MAX_DELAY * MAX_BINS;
  localparam int WDEPTH = MAX_WINDOW * MAX_BINS;
  localparam int DA_W   = dvmm_pkg::addr_w(DDEPTH);
  localparam int WA_W   = dvmm_pkg::addr_w(WDEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_ADD,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic [dvmm_pkg::DELAY_FRAMES_W-1:0]  delay_frames;
  logic [dvmm_pkg::WINDOW_FRAMES_W-1:0] window_frames;
  logic [dvmm_pkg::FRAME_LEN_W-1:0]     frame_len;
  logic                                 real_only;

  // Frame bookkeeping
  logic [DCNT_W-1:0] delay_count;
  logic [DCNT_W-1:0] delay_head;
  logic [WCNT_W-1:0] window_count;
  logic [WCNT_W-1:0] window_head;
  logic [BIN_W-1:0]  bin_counter;

  // Per-item registers
  logic signed [SAMPLE_BITS-1:0] x_re, x_im;
  logic signed [SAMPLE_BITS-1:0] v_re, v_im;
  logic [BIN_W-1:0]  b_q;
  logic [WCNT_W-1:0] n_q;
  logic [WCNT_W-1:0] wslot_q;
  logic              last_q, dfull_q, entered_q, wfull_q, wzero_q;

  // Effective configuration
  logic [DCNT_W-1:0] d_eff;
  logic [WCNT_W-1:0] w_eff;
  logic [LEN_W-1:0]  l_eff;

  always_comb begin
    if (32'(delay_frames) > 32'(MAX_DELAY)) begin
      d_eff = DCNT_W'(MAX_DELAY);
    end else begin
      d_eff = DCNT_W'(delay_frames);
    end
    if (window_frames == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(window_frames) > 32'(MAX_WINDOW)) begin
      w_eff = WCNT_W'(MAX_WINDOW);
    end else begin
      w_eff = WCNT_W'(window_frames);
    end
    if (frame_len == '0) begin
      l_eff = LEN_W'(1);
    end else if (32'(frame_len) > 32'(MAX_BINS)) begin
      l_eff = LEN_W'(MAX_BINS);
    end else begin
      l_eff = LEN_W'(frame_len);
    end
  end

  // Slot selection for the bin being taken
  logic              accept;
  logic              dfull_c, entered_c, wfull_c, last_c;
  logic [DCNT_W:0]   dsum;
  logic [WCNT_W:0]   wsum;
  logic [DCNT_W-1:0] dslot_c, dhead_inc;
  logic [WCNT_W-1:0] wslot_c, whead_inc, n_c;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);

  assign dfull_c   = (d_eff != '0) && (delay_count >= d_eff);
  assign entered_c = (d_eff == '0) || dfull_c;
  assign wfull_c   = (window_count >= w_eff);
  assign dsum      = {1'b0, delay_head} + {1'b0, delay_count};
  assign wsum      = {1'b0, window_head} + {1'b0, window_count};
  assign n_c       = window_count + WCNT_W'(entered_c && !wfull_c);
  assign last_c    = (LEN_W'(bin_counter) + LEN_W'(1)) >= l_eff;
  assign dhead_inc = (delay_head + DCNT_W'(1) == d_eff) ? '0 : delay_head + DCNT_W'(1);
  assign whead_inc = (window_head + WCNT_W'(1) == w_eff) ? '0 : window_head + WCNT_W'(1);

  always_comb begin
    if (dfull_c) begin
      dslot_c = delay_head;
    end else if (dsum >= {1'b0, d_eff}) begin
      dslot_c = DCNT_W'(dsum - {1'b0, d_eff});
    end else begin
      dslot_c = DCNT_W'(dsum);
    end
    if (wfull_c) begin
      wslot_c = window_head;
    end else if (wsum >= {1'b0, w_eff}) begin
      wslot_c = WCNT_W'(wsum - {1'b0, w_eff});
    end else begin
      wslot_c = WCNT_W'(wsum);
    end
  end

  // Delay line store: read the oldest frame's bin and overwrite it in one access
  logic                  d_we;
  logic [DA_W-1:0]       d_addr;
  logic [SMP2_W-1:0]     d_rdata;
  logic signed [SAMPLE_BITS-1:0] in_im;

  assign in_im  = real_only ? '0 : sample_im;
  assign d_we   = accept && (d_eff != '0);
  assign d_addr = DA_W'(dslot_c) * DA_W'(MAX_BINS) + DA_W'(bin_counter);

  dvmm_ram #(
    .DEPTH (DDEPTH),
    .WIDTH (SMP2_W)
  ) u_delay_ram (
    .clk   (clk),
    .we    (d_we),
    .addr  (d_addr),
    .wdata ({sample_re, in_im}),
    .rdata (d_rdata)
  );

  // Sample that joins the window
  logic signed [SAMPLE_BITS-1:0] v_re_c, v_im_c;

  assign v_re_c = dfull_q ? d_rdata[SMP2_W-1:SAMPLE_BITS] : x_re;
  assign v_im_c = dfull_q ? d_rdata[SAMPLE_BITS-1:0]      : x_im;

  // Window store
  logic                w_we;
  logic [WA_W-1:0]     w_addr;
  logic [SMP2_W-1:0]   w_rdata;

  assign w_we   = (state == S_RD1) && entered_q;
  assign w_addr = WA_W'(wslot_q) * WA_W'(MAX_BINS) + WA_W'(b_q);

  dvmm_ram #(
    .DEPTH (WDEPTH),
    .WIDTH (SMP2_W)
  ) u_window_ram (
    .clk   (clk),
    .we    (w_we),
    .addr  (w_addr),
    .wdata ({v_re_c, v_im_c}),
    .rdata (w_rdata)
  );

  // Per-bin sums
  logic                     s_we;
  logic [BIN_W-1:0]         s_addr;
  logic [2*SUM_W-1:0]       s_rdata;
  logic signed [SUM_W-1:0]  old_re, old_im, sub_re, sub_im, sum_re, sum_im;
  logic signed [SAMPLE_BITS-1:0] out_re, out_im;

  assign s_we   = (state == S_ADD) && entered_q;
  assign s_addr = (state == S_IDLE) ? bin_counter : b_q;

  // An empty window reads every sum as zero, whatever the sum store holds
  assign old_re = wzero_q ? '0 : s_rdata[2*SUM_W-1:SUM_W];
  assign old_im = wzero_q ? '0 : s_rdata[SUM_W-1:0];
  assign out_re = w_rdata[SMP2_W-1:SAMPLE_BITS];
  assign out_im = w_rdata[SAMPLE_BITS-1:0];
  assign sub_re = wfull_q ? SUM_W'(out_re) : '0;
  assign sub_im = wfull_q ? SUM_W'(out_im) : '0;
  assign sum_re = entered_q ? old_re - sub_re + SUM_W'(v_re) : old_re;
  assign sum_im = entered_q ? old_im - sub_im + SUM_W'(v_im) : old_im;

  dvmm_ram #(
    .DEPTH (MAX_BINS),
    .WIDTH (2 * SUM_W)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .addr  (s_addr),
    .wdata ({sum_re, sum_im}),
    .rdata (s_rdata)
  );

  // Shared divider
  logic                          div_start, div_done;
  logic signed [SAMPLE_BITS-1:0] quo_re, quo_im;

  assign div_start = (state == S_ADD) && (n_q != '0);

  dvmm_divider #(
    .NUM_W (SUM_W),
    .DEN_W (WCNT_W),
    .QUO_W (SAMPLE_BITS)
  ) u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_re (sum_re),
    .num_im (sum_im),
    .den    (n_q),
    .done   (div_done),
    .quo_re (quo_re),
    .quo_im (quo_im)
  );

  logic can_load;
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      delay_frames  <= dvmm_pkg::DELAY_FRAMES_RST;
      window_frames <= dvmm_pkg::WINDOW_FRAMES_RST;
      frame_len     <= dvmm_pkg::FRAME_LEN_RST;
      real_only     <= 1'b0;
      delay_count   <= '0;
      delay_head    <= '0;
      window_count  <= '0;
      window_head   <= '0;
      bin_counter   <= '0;
    end else begin
      if (state == S_FIN && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_write_en) begin
        case (dvmm_pkg::cfg_reg_t'(cfg_index))
          dvmm_pkg::CFG_DELAY_FRAMES: begin
            delay_frames <= cfg_data[dvmm_pkg::DELAY_FRAMES_W-1:0];
          end
          dvmm_pkg::CFG_WINDOW_FRAMES: begin
            window_frames <= cfg_data[dvmm_pkg::WINDOW_FRAMES_W-1:0];
          end
          dvmm_pkg::CFG_FRAME_LEN: begin
            frame_len <= cfg_data[dvmm_pkg::FRAME_LEN_W-1:0];
          end
          dvmm_pkg::CFG_REAL_ONLY: begin
            real_only <= cfg_data[0];
          end
          default: begin
          end
        endcase
        // Restart on any sizing register
        if (cfg_index == dvmm_pkg::CFG_DELAY_FRAMES ||
            cfg_index == dvmm_pkg::CFG_WINDOW_FRAMES ||
            cfg_index == dvmm_pkg::CFG_FRAME_LEN) begin
          delay_count  <= '0;
          delay_head   <= '0;
          window_count <= '0;
          window_head  <= '0;
          bin_counter  <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            x_re      <= sample_re;
            x_im      <= in_im;
            b_q       <= bin_counter;
            n_q       <= n_c;
            last_q    <= last_c;
            dfull_q   <= dfull_c;
            entered_q <= entered_c;
            wfull_q   <= wfull_c;
            wzero_q   <= (window_count == '0);
            wslot_q   <= wslot_c;
            // Advance frame bookkeeping at the end of a frame
            if (last_c) begin
              bin_counter <= '0;
              if (d_eff != '0) begin
                if (dfull_c) begin
                  delay_head <= dhead_inc;
                end else begin
                  delay_count <= delay_count + DCNT_W'(1);
                end
              end
              if (entered_c) begin
                if (wfull_c) begin
                  window_head <= whead_inc;
                end else begin
                  window_count <= window_count + WCNT_W'(1);
                end
              end
            end else begin
              bin_counter <= bin_counter + BIN_W'(1);
            end
            state <= S_RD1;
          end
        end
        S_RD1: begin
          v_re  <= v_re_c;
          v_im  <= v_im_c;
          state <= S_ADD;
        end
        S_ADD: begin
          state <= (n_q != '0) ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (can_load) begin
            mean_re          <= (n_q == '0) ? '0 : quo_re;
            mean_im          <= (n_q == '0 || real_only) ? '0 : quo_im;
            frames_in_window <= n_q;
            window_empty     <= (n_q == '0);
            bin_number       <= b_q;
            frame_end        <= last_q;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/dvmm_ram.sv
module dvmm_ram #(
  parameter int DEPTH = dvmm_pkg::DEF_MAX_BINS,
  parameter int WIDTH = 2 * dvmm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [dvmm_pkg::addr_w(DEPTH)-1:0]     addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/dvmm_divider.sv
module dvmm_divider #(
  parameter int NUM_W = dvmm_pkg::DEF_SAMPLE_BITS + 5,
  parameter int DEN_W = 6,
  parameter int QUO_W = dvmm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num_re,
  input  logic signed [NUM_W-1:0] num_im,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [QUO_W-1:0] quo_re,
  output logic signed [QUO_W-1:0] quo_im
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] q      [2];
  logic [DEN_W-1:0] r      [2];
  logic             neg    [2];
  logic [NUM_W-1:0] q_next [2];
  logic [DEN_W-1:0] r_next [2];
  logic [NUM_W-1:0] mag    [2];
  logic [NUM_W-1:0] quo    [2];

  assign mag[0] = num_re[NUM_W-1] ? NUM_W'(-num_re) : NUM_W'(num_re);
  assign mag[1] = num_im[NUM_W-1] ? NUM_W'(-num_im) : NUM_W'(num_im);

  // One restoring step per lane, both lanes share the count
  always_comb begin
    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    for (int i = 0; i < 2; i++) begin
      shifted = {r[i], q[i][NUM_W-1]};
      diff    = shifted - {1'b0, den_q};
      if (!diff[DEN_W]) begin
        r_next[i] = diff[DEN_W-1:0];
        q_next[i] = {q[i][NUM_W-2:0], 1'b1};
      end else begin
        r_next[i] = shifted[DEN_W-1:0];
        q_next[i] = {q[i][NUM_W-2:0], 1'b0};
      end
      quo[i] = neg[i] ? NUM_W'(-q[i]) : q[i];
    end
  end

  assign quo_re = quo[0][QUO_W-1:0];
  assign quo_im = quo[1][QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        for (int i = 0; i < 2; i++) begin
          q[i] <= q_next[i];
          r[i] <= r_next[i];
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
        den_q  <= den;
        q[0]   <= mag[0];
        q[1]   <= mag[1];
        r[0]   <= '0;
        r[1]   <= '0;
        neg[0] <= num_re[NUM_W-1];
        neg[1] <= num_im[NUM_W-1];
      end
    end
  end

endmodule

// File: test/delayed_vector_moving_mean_tb.sv
module delayed_vector_moving_mean_tb;

  localparam int MAX_BINS        = dvmm_pkg::DEF_MAX_BINS;
  localparam int MAX_WINDOW      = dvmm_pkg::DEF_MAX_WINDOW;
  localparam int MAX_DELAY       = dvmm_pkg::DEF_MAX_DELAY;
  localparam int SAMPLE_W        = dvmm_pkg::DEF_SAMPLE_BITS;
  localparam int CFG_IDX_W       = dvmm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = dvmm_pkg::CFG_DATA_W;
  localparam int DELAY_FRAMES_W  = dvmm_pkg::DELAY_FRAMES_W;
  localparam int WINDOW_FRAMES_W = dvmm_pkg::WINDOW_FRAMES_W;
  localparam int FRAME_LEN_W     = dvmm_pkg::FRAME_LEN_W;
  localparam int WCNT_W       = $clog2(dvmm_pkg::DEF_MAX_WINDOW + 1);
  localparam int BIN_W        = dvmm_pkg::addr_w(dvmm_pkg::DEF_MAX_BINS);
  localparam int NUM_CFG_REGS = 4;
  localparam int ITEM_LATENCY = dvmm_pkg::DEF_SAMPLE_BITS + $clog2(dvmm_pkg::DEF_MAX_WINDOW) + 5;
  localparam int RANDOM_BINS  = 1850;
  localparam int MAX_CYCLES   = 1000000;
  localparam int PHASE_CAP    = 400;
  localparam int HOLD_CYCLES  = 400;

  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } bin_sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_re;
    logic signed [SAMPLE_W-1:0] mean_im;
    logic [WCNT_W-1:0]          frames;
    logic                       empty;
    logic [BIN_W-1:0]           bin;
    logic                       last;
  } mean_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_re = '0;
  logic signed [SAMPLE_W-1:0] sample_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] mean_re;
  logic signed [SAMPLE_W-1:0] mean_im;
  logic [WCNT_W-1:0] frames_in_window;
  logic window_empty;
  logic [BIN_W-1:0] bin_number;
  logic frame_end;

  delayed_vector_moving_mean uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_re        (sample_re),
    .sample_im        (sample_im),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mean_re          (mean_re),
    .mean_im          (mean_im),
    .frames_in_window (frames_in_window),
    .window_empty     (window_empty),
    .bin_number       (bin_number),
    .frame_end        (frame_end)
  );

  always #5 clk = ~clk;

  // Predictor state: registers, delay line, window and per-bin sums
  logic [DELAY_FRAMES_W-1:0]  cfg_delay;
  logic [WINDOW_FRAMES_W-1:0] cfg_window;
  logic [FRAME_LEN_W-1:0]     cfg_len;
  logic                       cfg_real_only;
  logic signed [SAMPLE_W-1:0] dly_re [MAX_DELAY][MAX_BINS];
  logic signed [SAMPLE_W-1:0] dly_im [MAX_DELAY][MAX_BINS];
  logic signed [SAMPLE_W-1:0] win_re [MAX_WINDOW][MAX_BINS];
  logic signed [SAMPLE_W-1:0] win_im [MAX_WINDOW][MAX_BINS];
  longint sum_re [MAX_BINS];
  longint sum_im [MAX_BINS];
  int unsigned dly_count, dly_head, win_count, win_head, bin_pos;

  bin_sample_t  pending_bins [$];
  mean_result_t mean_queue [$];
  int queued_bins = 0;
  int accepted_bins = 0;
  int results_seen = 0;
  int random_bins = 0;
  int cycles = 0;
  bit failed = 1'b0;

  function automatic void restart_window();
    for (int i = 0; i < MAX_BINS; i++) begin
      sum_re[i] = 0;
      sum_im[i] = 0;
    end
    dly_count = 0;
    dly_head = 0;
    win_count = 0;
    win_head = 0;
    bin_pos = 0;
  endfunction

  function automatic int unsigned eff_delay(input int unsigned d);
    return (d > MAX_DELAY) ? MAX_DELAY : d;
  endfunction

  function automatic int unsigned eff_window(input int unsigned w);
    return (w == 0) ? 1 : (w > MAX_WINDOW) ? MAX_WINDOW : w;
  endfunction

  function automatic int unsigned eff_len(input int unsigned l);
    return (l == 0) ? 1 : (l > MAX_BINS) ? MAX_BINS : l;
  endfunction

  function automatic mean_result_t predict_bin(input logic signed [SAMPLE_W-1:0] x_re,
                                               input logic signed [SAMPLE_W-1:0] x_im_raw);
    int unsigned dly, win, len, b, slot, n;
    logic signed [SAMPLE_W-1:0] x_im, v_re, v_im;
    bit entered, dfull, wfull, last;
    longint q_re, q_im;
    mean_result_t r;
    dly = eff_delay(cfg_delay);
    win = eff_window(cfg_window);
    len = eff_len(cfg_len);
    b = bin_pos % len;
    x_im = cfg_real_only ? '0 : x_im_raw;
    v_re = x_re;
    v_im = x_im;
    entered = (dly == 0);
    dfull = 1'b0;
    if (dly != 0) begin
      dfull = (dly_count >= dly);
      if (dfull) begin
        // oldest frame leaves the delay line and its slot takes the new bin
        slot = dly_head % dly;
        v_re = dly_re[slot][b];
        v_im = dly_im[slot][b];
        entered = 1'b1;
      end else begin
        slot = (dly_head + dly_count) % dly;
      end
      dly_re[slot][b] = x_re;
      dly_im[slot][b] = x_im;
    end
    wfull = (win_count >= win);
    if (entered) begin
      if (wfull) begin
        slot = win_head % win;
        sum_re[b] -= win_re[slot][b];
        sum_im[b] -= win_im[slot][b];
      end else begin
        slot = (win_head + win_count) % win;
      end
      sum_re[b] += v_re;
      sum_im[b] += v_im;
      win_re[slot][b] = v_re;
      win_im[slot][b] = v_im;
    end
    n = win_count + ((entered && !wfull) ? 1 : 0);
    if (n > win) n = win;
    q_re = 0;
    q_im = 0;
    if (n != 0) begin
      q_re = sum_re[b] / longint'(n);
      if (!cfg_real_only) q_im = sum_im[b] / longint'(n);
    end
    last = (b + 1 >= len);
    r.mean_re = q_re[SAMPLE_W-1:0];
    r.mean_im = q_im[SAMPLE_W-1:0];
    r.frames = n[WCNT_W-1:0];
    r.empty = (n == 0);
    r.bin = b[BIN_W-1:0];
    r.last = last;
    if (last) begin
      bin_pos = 0;
      if (dly != 0) begin
        if (dfull) dly_head = (dly_head + 1) % dly;
        else dly_count++;
      end
      if (entered) begin
        if (wfull) win_head = (win_head + 1) % win;
        else win_count++;
      end
    end else begin
      bin_pos = b + 1;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_bin(input logic signed [SAMPLE_W-1:0] re, input logic signed [SAMPLE_W-1:0] im);
    bin_sample_t s;
    s.re = re;
    s.im = im;
    pending_bins.push_back(s);
    queued_bins++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      dvmm_pkg::CFG_DELAY_FRAMES: begin
        cfg_delay = data[DELAY_FRAMES_W-1:0];
        restart_window();
      end
      dvmm_pkg::CFG_WINDOW_FRAMES: begin
        cfg_window = data[WINDOW_FRAMES_W-1:0];
        restart_window();
      end
      dvmm_pkg::CFG_FRAME_LEN: begin
        cfg_len = data[FRAME_LEN_W-1:0];
        restart_window();
      end
      dvmm_pkg::CFG_REAL_ONLY: cfg_real_only = data[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (accepted_bins != queued_bins || mean_queue.size() != 0) @(posedge clk);
  endtask

  // Once drained, write the sizing registers on a restart and real_only, then queue random bins
  task automatic run_phase(input bit restart, input int unsigned d, input int unsigned w,
                           input int unsigned l, input bit ro, input int n_bins);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    if (restart) begin
      data = CFG_DATA_W'($urandom);
      data[DELAY_FRAMES_W-1:0] = d[DELAY_FRAMES_W-1:0];
      write_reg(dvmm_pkg::CFG_DELAY_FRAMES, data);
      data = CFG_DATA_W'($urandom);
      data[WINDOW_FRAMES_W-1:0] = w[WINDOW_FRAMES_W-1:0];
      write_reg(dvmm_pkg::CFG_WINDOW_FRAMES, data);
      write_reg(dvmm_pkg::CFG_FRAME_LEN, l[FRAME_LEN_W-1:0]);
    end
    data = CFG_DATA_W'($urandom);
    data[0] = ro;
    write_reg(dvmm_pkg::CFG_REAL_ONLY, data);
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(NUM_CFG_REGS, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_write_en <= 1'b0;
    for (int i = 0; i < n_bins; i++) push_bin(random_value(), random_value());
    random_bins += n_bins;
  endtask

  // Driver: bursts of transfers separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    bin_sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        mean_queue.push_back(predict_bin(sample_re, sample_im));
        accepted_bins++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_bins.size() != 0) begin
        s = pending_bins.pop_front();
        in_valid <= 1'b1;
        sample_re <= s.re;
        sample_im <= s.im;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result, stall on a pattern with occasional long holds
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = STALL_NONE;

  task automatic check_field(input string name, input longint want, input longint got);
    if (want !== got) begin
      failed = 1'b1;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    mean_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mean_queue.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result: expected none, actual bin %0d mean %0d/%0d",
                   $time, bin_number, mean_re, mean_im);
        end else begin
          want = mean_queue.pop_front();
          check_field("mean_re", $signed(want.mean_re), mean_re);
          check_field("mean_im", $signed(want.mean_im), mean_im);
          check_field("frames_in_window", want.frames, frames_in_window);
          check_field("window_empty", want.empty, window_empty);
          check_field("bin_number", want.bin, bin_number);
          check_field("frame_end", want.last, frame_end);
        end
        results_seen++;
        if (results_seen % 500 == 250) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (stall_mode)
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("delayed_vector_moving_mean_tb failed");
      $finish;
    end
  end

  initial begin
    bit restart;
    int unsigned d, w, l;
    int n;
    cfg_delay = dvmm_pkg::DELAY_FRAMES_RST;
    cfg_window = dvmm_pkg::WINDOW_FRAMES_RST;
    cfg_len = dvmm_pkg::FRAME_LEN_RST;
    cfg_real_only = 1'b0;
    restart_window();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Default registers: first frame, so each mean is the sample itself
    push_bin(16'sh7FFF, 16'sh8000);
    push_bin(16'sh8000, 16'sh7FFF);
    push_bin(16'sh0000, 16'sh0000);
    push_bin(16'shFFFF, 16'sh0001);
    push_bin(16'sh0001, 16'shFFFF);
    push_bin(16'sh7FFF, 16'sh7FFF);

    // Two-frame delay into a two-frame window, one bin per frame, real only:
    // empty window first, then full-scale sums and rounding toward zero
    wait_idle();
    write_reg(dvmm_pkg::CFG_DELAY_FRAMES, CFG_DATA_W'(2));
    write_reg(dvmm_pkg::CFG_WINDOW_FRAMES, CFG_DATA_W'(2));
    write_reg(dvmm_pkg::CFG_FRAME_LEN, CFG_DATA_W'(1));
    write_reg(dvmm_pkg::CFG_REAL_ONLY, CFG_DATA_W'(1));
    @(posedge clk);
    cfg_write_en <= 1'b0;
    push_bin(16'sh8000, 16'sh7FFF);
    push_bin(16'sh8000, 16'sh8000);
    push_bin(16'sh8000, 16'sh1234);
    push_bin(16'sh8000, 16'shFFFF);
    push_bin(-16'sd3, 16'sh7FFF);
    push_bin(16'sh0000, 16'sh8000);
    push_bin(16'sh7FFF, 16'sh0001);
    push_bin(16'sh7FFF, 16'sh7FFF);
    push_bin(16'sh7FFF, 16'sh0000);
    push_bin(16'sh0001, 16'sh8000);

    // Register extremes, including out-of-range values
    run_phase(1'b1, MAX_DELAY, MAX_WINDOW, 1, 1'b0, 120);
    run_phase(1'b1, (1 << DELAY_FRAMES_W) - 1, (1 << WINDOW_FRAMES_W) - 1, 2, 1'b1, 140);
    run_phase(1'b1, 0, 0, MAX_BINS, 1'b0, 300);
    run_phase(1'b1, 5, 3, 0, 1'b1, 60);
    run_phase(1'b1, 1, 1, (1 << FRAME_LEN_W) - 1, 1'b0, 270);
    d = 1;
    w = 1;
    l = (1 << FRAME_LEN_W) - 1;

    while (random_bins < RANDOM_BINS) begin
      restart = ($urandom_range(0, 3) != 0);
      if (restart) begin
        d = $urandom_range(0, 20);
        w = $urandom_range(0, 40);
        l = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
        n = eff_len(l) * (eff_delay(d) + eff_window(w) + $urandom_range(0, 4))
            + $urandom_range(0, eff_len(l) - 1);
        if (n > PHASE_CAP) n = PHASE_CAP;
      end else begin
        n = $urandom_range(5, 80);
      end
      if (n > RANDOM_BINS - random_bins) n = RANDOM_BINS - random_bins;
      run_phase(restart, d, w, l, $urandom_range(0, 1), n);
    end

    wait_idle();
    repeat (2 * ITEM_LATENCY) @(posedge clk);
    if (!failed && mean_queue.size() == 0) begin
      $display("delayed_vector_moving_mean_tb passed");
    end else begin
      $display("delayed_vector_moving_mean_tb failed");
    end
    $finish;
  end

endmodule
